### sv/tfps_pkg.sv
// Shared types, constants and register codes for the tilt fusion PID steering block.
// No dependencies; used by tfps_mac, tfps_core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tfps_pkg;

  // Stream payload widths (bytes rounded up)
  localparam int IN_W  = 48;
  localparam int OUT_W = 96;

  // Datapath widths
  localparam int SAMPLE_W = 16;
  localparam int GYRO_W   = 17;
  localparam int ANGLE_W  = 40;
  localparam int ERR_W    = 41;
  localparam int INTEG_W  = 32;
  localparam int GAIN_W   = 32;
  localparam int ILIM_W   = 31;
  localparam int CLIM_W   = 7;
  localparam int SERVO_W  = 9;
  localparam int CORR_W   = 8;

  // Shared multiplier: signed 25 x signed 32, wide accumulator
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 32;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 82;

  // Fixed constants of the control law
  localparam logic signed [GYRO_W-1:0] GYRO_BIAS    = 17'sd18;
  localparam logic signed [GYRO_W:0]   GYRO_SPIKE   = 18'sd5000;
  localparam logic signed [SAMPLE_W-1:0] MIN_SPEED  = 16'sd20;
  localparam logic signed [SERVO_W:0]  SERVO_CENTRE = 10'sd159;

  // Config register reset values
  localparam logic [GAIN_W-1:0] RST_ACCEL_GAIN = 32'd26844;
  localparam logic [GAIN_W-1:0] RST_GYRO_GAIN  = 32'd68451;
  localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 32'd771752;
  localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 32'd5033;
  localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = 32'hFFFE_D289;  // -77175
  localparam logic [GAIN_W-1:0] RST_OFFSET     = 32'd9175040;
  localparam logic [ILIM_W-1:0] RST_INTEG_LIM  = 31'd400000;
  localparam logic [CLIM_W-1:0] RST_CORR_LIM   = 7'd24;

  typedef enum logic [2:0] {
    REG_ACCEL_GAIN = 3'd0,
    REG_GYRO_GAIN  = 3'd1,
    REG_PROP_GAIN  = 3'd2,
    REG_INTEG_GAIN = 3'd3,
    REG_DERIV_GAIN = 3'd4,
    REG_OFFSET     = 3'd5,
    REG_INTEG_LIM  = 3'd6,
    REG_CORR_LIM   = 3'd7
  } cfg_idx_t;

  // Left shift applied to a product before it is accumulated
  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_16 = 2'd1,
    SH_24 = 2'd2,
    SH_40 = 2'd3
  } shift_t;

  typedef struct packed {
    logic                      valid;
    logic                      clear;
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
    shift_t                    shift;
  } mac_cmd_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] accel_gain;
    logic signed [GAIN_W-1:0] gyro_gain;
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic signed [GAIN_W-1:0] angle_offset;
    logic [ILIM_W-1:0]        integ_limit;
    logic [CLIM_W-1:0]        corr_limit;
  } cfg_t;

  typedef struct packed {
    logic [SERVO_W-1:0]        servo_duty;
    logic signed [CORR_W-1:0]  steer_correction;
    logic signed [ANGLE_W-1:0] tilt_angle;
    logic signed [INTEG_W-1:0] integral_value;
  } result_t;

endpackage

`default_nettype wire

### sv/tilt_fusion_pid_steering_top.sv
// Top level of the tilt fusion PID steering block: config registers, stream
// ports, output register. Depends on tfps_pkg, tfps_mac, tfps_core.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//  - Input stream s_axis_*: one word per control tick (accel, gyro, speed).
//  - Output stream m_axis_*: one result word per input word, in order.
//  - Config port: cfg_we/cfg_addr/cfg_wdata write one register per cycle;
//    write only while no word is in flight.
// Timing
//  - A word goes through one shared 25x32 multiplier-accumulator under a
//    sequencer: 3 products for the filter, 5 more for the PID.
//  - A word with speed below 20 skips the PID products.
//  - The sequencer takes a new word only when done with the last one;
//    s_axis_tready is high only while the sequencer is idle.
// Reset (rst, synchronous, active high)
//  - Registers return to their defaults, the tilt state clears and will be
//    seeded by the next accel sample, integral and gyro history clear.
// Stall
//  - A finished word waits in the output register; the next input word is
//    still accepted and runs. Its result holds in the sequencer until the
//    output register frees up, and input stays blocked meanwhile.
module tilt_fusion_pid_steering_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // [15:0] accel_sample, [31:16] gyro_sample, [47:32] speed_count
  input  wire logic [tfps_pkg::IN_W-1:0]      s_axis_tdata,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [8:0] servo_duty, [16:9] steer_correction, [56:17] tilt_angle,
  // [88:57] integral_value, [95:89] zero
  output logic [tfps_pkg::OUT_W-1:0]          m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  input  wire logic                           cfg_we,
  input  wire logic [2:0]                     cfg_addr,
  input  wire logic [tfps_pkg::GAIN_W-1:0]    cfg_wdata
);

  tfps_pkg::cfg_t     cfg;
  tfps_pkg::mac_cmd_t mac_cmd;
  tfps_pkg::result_t  res;
  logic signed [tfps_pkg::ACC_W-1:0] acc;
  logic core_done;
  logic take;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accel_gain   <= tfps_pkg::RST_ACCEL_GAIN;
      cfg.gyro_gain    <= tfps_pkg::RST_GYRO_GAIN;
      cfg.prop_gain    <= tfps_pkg::RST_PROP_GAIN;
      cfg.integ_gain   <= tfps_pkg::RST_INTEG_GAIN;
      cfg.deriv_gain   <= tfps_pkg::RST_DERIV_GAIN;
      cfg.angle_offset <= tfps_pkg::RST_OFFSET;
      cfg.integ_limit  <= tfps_pkg::RST_INTEG_LIM;
      cfg.corr_limit   <= tfps_pkg::RST_CORR_LIM;
    end else if (cfg_we) begin
      unique case (tfps_pkg::cfg_idx_t'(cfg_addr))
        tfps_pkg::REG_ACCEL_GAIN: cfg.accel_gain   <= cfg_wdata;
        tfps_pkg::REG_GYRO_GAIN:  cfg.gyro_gain    <= cfg_wdata;
        tfps_pkg::REG_PROP_GAIN:  cfg.prop_gain    <= cfg_wdata;
        tfps_pkg::REG_INTEG_GAIN: cfg.integ_gain   <= cfg_wdata;
        tfps_pkg::REG_DERIV_GAIN: cfg.deriv_gain   <= cfg_wdata;
        tfps_pkg::REG_OFFSET:     cfg.angle_offset <= cfg_wdata;
        tfps_pkg::REG_INTEG_LIM:  cfg.integ_limit  <= cfg_wdata[tfps_pkg::ILIM_W-1:0];
        tfps_pkg::REG_CORR_LIM:   cfg.corr_limit   <= cfg_wdata[tfps_pkg::CLIM_W-1:0];
        default: ;
      endcase
    end
  end

  tfps_mac u_mac (
    .clk (clk),
    .rst (rst),
    .cmd (mac_cmd),
    .acc (acc)
  );

  tfps_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .accel_in (s_axis_tdata[15:0]),
    .gyro_in  (s_axis_tdata[31:16]),
    .speed_in (s_axis_tdata[47:32]),
    .done     (core_done),
    .take     (take),
    .res      (res),
    .mac_cmd  (mac_cmd),
    .acc      (acc)
  );

  // Output register: loads when empty or being drained this cycle
  assign take = core_done && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
    if (take) begin
      m_axis_tdata <= {7'b0, res.integral_value, res.tilt_angle,
                       res.steer_correction, res.servo_duty};
    end
  end

endmodule

`default_nettype wire

### sv/tfps_mac.sv
// Shared multiply-accumulate unit: registered 25x32 signed product, then
// shifted accumulate into a wide register. Depends on tfps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfps_mac (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire tfps_pkg::mac_cmd_t                   cmd,
  output logic signed [tfps_pkg::ACC_W-1:0]         acc
);

  logic signed [tfps_pkg::PROD_W-1:0] prod;
  logic                               pvalid;
  logic                               pclear;
  tfps_pkg::shift_t                   psh;
  logic signed [tfps_pkg::ACC_W-1:0]  pext;
  logic signed [tfps_pkg::ACC_W-1:0]  shifted;

  // stage 1: product
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else begin
      pvalid <= cmd.valid;
    end
    prod   <= cmd.a * cmd.b;
    pclear <= cmd.clear;
    psh    <= cmd.shift;
  end

  always_comb begin
    pext = {{(tfps_pkg::ACC_W - tfps_pkg::PROD_W){prod[tfps_pkg::PROD_W-1]}}, prod};
    case (psh)
      tfps_pkg::SH_0:  shifted = pext;
      tfps_pkg::SH_16: shifted = pext <<< 16;
      tfps_pkg::SH_24: shifted = pext <<< 24;
      tfps_pkg::SH_40: shifted = pext <<< 40;
      default:         shifted = pext;
    endcase
  end

  // stage 2: accumulate (first term of a sum overwrites)
  always_ff @(posedge clk) begin
    if (pvalid) begin
      acc <= pclear ? shifted : acc + shifted;
    end
  end

endmodule

`default_nettype wire

### sv/tfps_core.sv
// Sequencer and state of the tilt filter and PID: drives the shared MAC
// through the filter and PID sums. Depends on tfps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfps_core (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire tfps_pkg::cfg_t                          cfg,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic signed [tfps_pkg::SAMPLE_W-1:0]    accel_in,
  input  wire logic signed [tfps_pkg::SAMPLE_W-1:0]    gyro_in,
  input  wire logic signed [tfps_pkg::SAMPLE_W-1:0]    speed_in,
  output logic                                         done,
  input  wire logic                                    take,
  output tfps_pkg::result_t                            res,
  output tfps_pkg::mac_cmd_t                           mac_cmd,
  input  wire logic signed [tfps_pkg::ACC_W-1:0]       acc
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_PREP   = 10'b00_0000_0010,
    ST_FMAC   = 10'b00_0000_0100,
    ST_FWAIT  = 10'b00_0000_1000,
    ST_ANGLE  = 10'b00_0001_0000,
    ST_ERR    = 10'b00_0010_0000,
    ST_PMAC   = 10'b00_0100_0000,
    ST_PWAIT  = 10'b00_1000_0000,
    ST_FINISH = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_t;

  localparam int SW = tfps_pkg::SAMPLE_W;
  localparam int GW = tfps_pkg::GYRO_W;
  localparam int AW = tfps_pkg::ANGLE_W;
  localparam int EW = tfps_pkg::ERR_W;
  localparam int IW = tfps_pkg::INTEG_W;
  localparam int MA = tfps_pkg::MUL_A_W;
  localparam int XW = tfps_pkg::ACC_W;
  localparam int STEP_W = XW - 24;
  localparam int Q_W    = XW - 40;
  localparam int T_W    = IW + 17;
  localparam int NI_W   = T_W - 16 + 1;

  state_t state;
  logic [2:0] op;

  logic signed [SW-1:0] accel, gyro, speed;
  logic signed [GW-1:0] g_cur, prev_gyro;
  logic signed [EW-1:0] diff, err;
  logic signed [AW-1:0] filtered;
  logic                 seeded;
  logic signed [IW-1:0] integral;
  logic                 speed_ok;

  // PREP
  logic signed [GW-1:0] g_biased, g_new;
  logic signed [GW:0]   jump;
  logic signed [31:0]   accel_q;
  logic signed [AW-1:0] base;
  logic signed [EW-1:0] diff_new;
  logic signed [GW:0]   g_neg;

  // ANGLE
  logic signed [STEP_W-1:0] na_wide;
  logic signed [AW-1:0]     na;

  // FINISH
  logic signed [Q_W-1:0]  corr_t, corr_c, lim_pos;
  logic signed [T_W-1:0]  t_sum;
  logic signed [NI_W-1:0] ni, ilim_pos, ilim_neg;
  logic signed [IW-1:0]   ni_c;
  logic signed [tfps_pkg::CORR_W-1:0]  corr8;
  logic signed [tfps_pkg::SERVO_W:0]   servo10;

  assign in_ready = (state == ST_IDLE);
  assign done     = (state == ST_DONE);

  always_comb begin
    g_biased = $signed({gyro[SW-1], gyro}) + tfps_pkg::GYRO_BIAS;
    jump     = $signed({g_biased[GW-1], g_biased}) - $signed({prev_gyro[GW-1], prev_gyro});
    g_new    = (jump > tfps_pkg::GYRO_SPIKE || jump < -tfps_pkg::GYRO_SPIKE) ?
               prev_gyro : g_biased;
    accel_q  = $signed({accel, 16'b0});
    base     = seeded ? filtered : $signed({{(AW-32){accel_q[31]}}, accel_q});
    diff_new = $signed({{(EW-32){accel_q[31]}}, accel_q}) - $signed({base[AW-1], base});
    g_neg    = -$signed({g_cur[GW-1], g_cur});
  end

  // Operand schedule for the shared MAC
  always_comb begin
    mac_cmd       = '0;
    mac_cmd.shift = tfps_pkg::SH_0;
    if (state == ST_FMAC) begin
      mac_cmd.valid = 1'b1;
      case (op)
        3'd0: begin
          mac_cmd.clear = 1'b1;
          mac_cmd.a     = $signed({1'b0, diff[23:0]});
          mac_cmd.b     = cfg.accel_gain;
        end
        3'd1: begin
          mac_cmd.a     = $signed({{(MA-17){diff[EW-1]}}, diff[EW-1:24]});
          mac_cmd.b     = cfg.accel_gain;
          mac_cmd.shift = tfps_pkg::SH_24;
        end
        default: begin
          mac_cmd.a     = $signed({{(MA-GW-1){g_neg[GW]}}, g_neg});
          mac_cmd.b     = cfg.gyro_gain;
          mac_cmd.shift = tfps_pkg::SH_16;
        end
      endcase
    end else if (state == ST_PMAC) begin
      mac_cmd.valid = 1'b1;
      case (op)
        3'd0: begin
          mac_cmd.clear = 1'b1;
          mac_cmd.a     = $signed({1'b0, err[23:0]});
          mac_cmd.b     = cfg.prop_gain;
        end
        3'd1: begin
          mac_cmd.a     = $signed({{(MA-17){err[EW-1]}}, err[EW-1:24]});
          mac_cmd.b     = cfg.prop_gain;
          mac_cmd.shift = tfps_pkg::SH_24;
        end
        3'd2: begin
          mac_cmd.a     = $signed({{(MA-GW){g_cur[GW-1]}}, g_cur});
          mac_cmd.b     = cfg.deriv_gain;
          mac_cmd.shift = tfps_pkg::SH_16;
        end
        3'd3: begin
          mac_cmd.a     = $signed({1'b0, integral[23:0]});
          mac_cmd.b     = cfg.integ_gain;
          mac_cmd.shift = tfps_pkg::SH_16;
        end
        default: begin
          mac_cmd.a     = $signed({{(MA-8){integral[IW-1]}}, integral[IW-1:24]});
          mac_cmd.b     = cfg.integ_gain;
          mac_cmd.shift = tfps_pkg::SH_40;
        end
      endcase
    end
  end

  // Angle update with saturation to the state width
  always_comb begin
    na_wide = $signed({{(STEP_W-AW){filtered[AW-1]}}, filtered}) + acc[XW-1:24];
    if ((&na_wide[STEP_W-1:AW-1]) || !(|na_wide[STEP_W-1:AW-1])) begin
      na = na_wide[AW-1:0];
    end else if (na_wide[STEP_W-1]) begin
      na = {1'b1, {(AW-1){1'b0}}};
    end else begin
      na = {1'b0, {(AW-1){1'b1}}};
    end
  end

  // Correction and integral (truncate toward zero, then clamp)
  always_comb begin
    corr_t  = acc[XW-1:40] + $signed({{(Q_W-1){1'b0}}, acc[XW-1] && (acc[39:16] != '0)});
    lim_pos = $signed({{(Q_W-tfps_pkg::CLIM_W){1'b0}}, cfg.corr_limit});
    if (corr_t > lim_pos)       corr_c = lim_pos;
    else if (corr_t < -lim_pos) corr_c = -lim_pos;
    else                        corr_c = corr_t;

    t_sum    = $signed({integral[IW-1], integral, 16'b0}) +
               $signed({{(T_W-EW){err[EW-1]}}, err});
    ni       = $signed({t_sum[T_W-1], t_sum[T_W-1:16]}) +
               $signed({{(NI_W-1){1'b0}}, t_sum[T_W-1] && (t_sum[15:0] != '0)});
    ilim_pos = $signed({{(NI_W-tfps_pkg::ILIM_W){1'b0}}, cfg.integ_limit});
    ilim_neg = -ilim_pos;
    if (ni > ilim_pos)      ni_c = ilim_pos[IW-1:0];
    else if (ni < ilim_neg) ni_c = ilim_neg[IW-1:0];
    else                    ni_c = ni[IW-1:0];

    corr8   = speed_ok ? corr_c[tfps_pkg::CORR_W-1:0] : '0;
    servo10 = tfps_pkg::SERVO_CENTRE + $signed({{2{corr8[tfps_pkg::CORR_W-1]}}, corr8});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= '0;
      seeded    <= 1'b0;
      filtered  <= '0;
      prev_gyro <= '0;
      integral  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            accel <= accel_in;
            gyro  <= gyro_in;
            speed <= speed_in;
            state <= ST_PREP;
          end
        end
        ST_PREP: begin
          g_cur     <= g_new;
          prev_gyro <= g_new;
          filtered  <= base;
          seeded    <= 1'b1;
          diff      <= diff_new;
          speed_ok  <= (speed >= tfps_pkg::MIN_SPEED);
          op        <= '0;
          state     <= ST_FMAC;
        end
        ST_FMAC: begin
          if (op == 3'd2) begin
            op    <= '0;
            state <= ST_FWAIT;
          end else begin
            op <= op + 3'd1;
          end
        end
        ST_FWAIT: state <= ST_ANGLE;
        ST_ANGLE: begin
          filtered <= na;
          state    <= ST_ERR;
        end
        ST_ERR: begin
          err   <= $signed({filtered[AW-1], filtered}) +
                   $signed({{(EW-32){cfg.angle_offset[31]}}, cfg.angle_offset});
          state <= speed_ok ? ST_PMAC : ST_FINISH;
        end
        ST_PMAC: begin
          if (op == 3'd4) begin
            op    <= '0;
            state <= ST_PWAIT;
          end else begin
            op <= op + 3'd1;
          end
        end
        ST_PWAIT: state <= ST_FINISH;
        ST_FINISH: begin
          if (speed_ok) integral <= ni_c;
          res.servo_duty       <= servo10[tfps_pkg::SERVO_W-1:0];
          res.steer_correction <= corr8;
          res.tilt_angle       <= filtered;
          res.integral_value   <= speed_ok ? ni_c : integral;
          state                <= ST_DONE;
        end
        ST_DONE: begin
          if (take) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
